// File: rtl/hlz_pkg.sv
// Shared types, codes and a helper function of the LZ stream decompressor.
`timescale 1ns / 1ps
package hlz_pkg;

  typedef enum logic [1:0] {
    CMD_FEED    = 2'd0,
    CMD_PULL    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_FEED,
    OP_PULL,
    OP_RESTART,
    OP_IGNORE
  } op_e;

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'd0,
    ST_REFUSE = 3'd1,
    ST_DATA   = 3'd2,
    ST_NEED   = 3'd3,
    ST_FINISH = 3'd4,
    ST_TRUNC  = 3'd5,
    ST_UNDER  = 3'd6
  } status_e;

  localparam logic [7:0] END_MARKER = 8'hFF;
  localparam logic [2:0] HDR_EXTENDED = 3'd7;

  typedef enum logic [2:0] {
    KIND_LITERAL  = 3'd0,
    KIND_RUN      = 3'd1,
    KIND_PAIR     = 3'd2,
    KIND_INCR     = 3'd3,
    KIND_COPY     = 3'd4,
    KIND_MIRROR   = 3'd5,
    KIND_BACKWARD = 3'd6,
    KIND_EXT      = 3'd7
  } kind_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic        block_last;
    logic [23:0] total_in;
    logic [23:0] total_out;
  } out_item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       last;
  } op_item_t;

  function automatic logic [7:0] mirror8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7 - k];
    end
    return r;
  endfunction

endpackage

// File: rtl/hlz_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
`timescale 1ns / 1ps
interface hlz_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/hlz_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module hlz_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/hlz_front.sv
// Front end: accepts input items, classifies the command and queues them.
`timescale 1ns / 1ps
module hlz_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  hlz_stream_if.sink          in_i,
  output logic                q_valid_o,
  output hlz_pkg::op_item_t   q_item_o,
  input  logic                q_pop_i
);
  localparam int QDepth = 2;

  hlz_pkg::op_item_t mem_q [QDepth];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              push;
  hlz_pkg::op_item_t cls;

  always_comb begin
    cls.data = in_i.payload.in_byte;
    cls.last = in_i.payload.in_last;
    unique case (hlz_pkg::cmd_e'(in_i.payload.command))
      hlz_pkg::CMD_FEED:    cls.op = hlz_pkg::OP_FEED;
      hlz_pkg::CMD_PULL:    cls.op = hlz_pkg::OP_PULL;
      hlz_pkg::CMD_RESTART: cls.op = hlz_pkg::OP_RESTART;
      default:              cls.op = hlz_pkg::OP_IGNORE;
    endcase
  end

  assign in_i.ready = (cnt_q != 2'(QDepth));
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end
endmodule

// File: rtl/hlz_back.sv
// Back end: header parsing, block expansion, history access and result register.
`timescale 1ns / 1ps
module hlz_back #(
  parameter int HISTORY_DEPTH = 65536,
  parameter int COUNT_WIDTH   = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  hlz_pkg::op_item_t q_item_i,
  output logic              q_pop_o,
  hlz_stream_if.source      out_o
);
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [COUNT_WIDTH-1:0] DepthCnt = COUNT_WIDTH'(HISTORY_DEPTH);
  localparam logic [16:0] DepthPos = 17'(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    PH_HEADER, PH_HEADER2, PH_OPER_A, PH_OPER_B, PH_LITERAL, PH_EMIT
  } phase_e;

  typedef enum logic [1:0] {
    END_RUNNING, END_FINISHED, END_TRUNC, END_UNDER
  } end_e;

  phase_e                 phase_q, phase_d;
  end_e                   end_q, end_d;
  hlz_pkg::kind_e         kind_q, kind_d;
  logic [11:0]            rem_q, rem_d;
  logic [7:0]             fhdr_q, fhdr_d;
  logic [7:0]             val_a_q, val_a_d;
  logic [7:0]             val_b_q, val_b_d;
  logic [16:0]            src_q, src_d;
  logic                   tog_q, tog_d;
  logic [COUNT_WIDTH-1:0] in_cnt_q, in_cnt_d;
  logic [COUNT_WIDTH-1:0] out_cnt_q, out_cnt_d;
  logic                   rd_pend_q, rd_pend_d;
  logic                   oob_q;
  logic                   out_vld_q;
  hlz_pkg::out_item_t     out_q, res;

  logic                   need_rd, issue, exec, out_free;
  logic [7:0]             rdata, hist_v;
  logic                   hist_we;
  logic [7:0]             hist_wd;
  logic                   blk_go;
  logic [2:0]             blk_cmd;
  logic [10:0]            blk_len;
  hlz_pkg::kind_e         blk_kind;
  logic [11:0]            rem_dec;

  assign out_free = !out_vld_q || out_o.ready;
  assign need_rd  = (q_item_i.op == hlz_pkg::OP_PULL) && (end_q == END_RUNNING)
                 && (phase_q == PH_EMIT)
                 && ((kind_q == hlz_pkg::KIND_COPY) || (kind_q == hlz_pkg::KIND_MIRROR)
                     || ((kind_q == hlz_pkg::KIND_BACKWARD) && (src_q != 17'd0)));
  assign issue    = q_valid_i && need_rd && !rd_pend_q;
  assign exec     = q_valid_i && out_free && (!need_rd || rd_pend_q);
  assign q_pop_o  = exec;
  assign hist_v   = oob_q ? 8'd0 : rdata;
  assign rem_dec  = rem_q - 12'd1;
  assign blk_kind = (blk_cmd == hlz_pkg::HDR_EXTENDED) ? hlz_pkg::KIND_COPY
                                                        : hlz_pkg::kind_e'(blk_cmd);

  hlz_ram #(.Width(8), .Depth(HISTORY_DEPTH)) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (out_cnt_q[AW-1:0]),
    .wdata_i (hist_wd),
    .re_i    (issue),
    .raddr_i (src_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    phase_d   = phase_q;
    end_d     = end_q;
    kind_d    = kind_q;
    rem_d     = rem_q;
    fhdr_d    = fhdr_q;
    val_a_d   = val_a_q;
    val_b_d   = val_b_q;
    src_d     = src_q;
    tog_d     = tog_q;
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    hist_we   = 1'b0;
    hist_wd   = 8'd0;
    blk_go    = 1'b0;
    blk_cmd   = 3'd0;
    blk_len   = 11'd0;
    res       = '0;
    res.status = hlz_pkg::ST_REFUSE;

    unique case (q_item_i.op)
      hlz_pkg::OP_FEED: begin
        if (end_q != END_RUNNING || phase_q == PH_EMIT) begin
          res.status = hlz_pkg::ST_REFUSE;
        end else begin
          in_cnt_d = (in_cnt_q == CountMax) ? CountMax : in_cnt_q + 1'b1;
          res.status = hlz_pkg::ST_ACCEPT;
          if (phase_q == PH_HEADER && q_item_i.data == hlz_pkg::END_MARKER) begin
            end_d      = END_FINISHED;
            res.status = hlz_pkg::ST_FINISH;
          end else if (q_item_i.last) begin
            end_d      = END_TRUNC;
            res.status = hlz_pkg::ST_TRUNC;
          end else begin
            unique case (phase_q)
              PH_HEADER: begin
                if (q_item_i.data[7:5] == hlz_pkg::HDR_EXTENDED) begin
                  fhdr_d  = q_item_i.data;
                  phase_d = PH_HEADER2;
                end else begin
                  blk_go  = 1'b1;
                  blk_cmd = q_item_i.data[7:5];
                  blk_len = {6'd0, q_item_i.data[4:0]} + 11'd1;
                end
              end
              PH_HEADER2: begin
                blk_go  = 1'b1;
                blk_cmd = fhdr_q[4:2];
                blk_len = {1'b0, fhdr_q[1:0], q_item_i.data} + 11'd1;
              end
              PH_OPER_A: begin
                val_a_d = q_item_i.data;
                phase_d = (kind_q == hlz_pkg::KIND_RUN || kind_q == hlz_pkg::KIND_INCR)
                        ? PH_EMIT : PH_OPER_B;
              end
              PH_OPER_B: begin
                val_b_d = q_item_i.data;
                if (kind_q != hlz_pkg::KIND_PAIR) begin
                  src_d = {1'b0, val_a_q, q_item_i.data};
                end
                phase_d = PH_EMIT;
              end
              default: begin
                val_a_d = q_item_i.data;
                phase_d = PH_EMIT;
              end
            endcase
          end
        end
      end
      hlz_pkg::OP_PULL: begin
        if (end_q == END_FINISHED) begin
          res.status = hlz_pkg::ST_FINISH;
        end else if (end_q == END_TRUNC) begin
          res.status = hlz_pkg::ST_TRUNC;
        end else if (end_q == END_UNDER) begin
          res.status = hlz_pkg::ST_UNDER;
        end else if (phase_q != PH_EMIT) begin
          res.status = hlz_pkg::ST_NEED;
        end else if (kind_q == hlz_pkg::KIND_BACKWARD && src_q == 17'd0) begin
          end_d      = END_UNDER;
          res.status = hlz_pkg::ST_UNDER;
        end else begin
          res.status = hlz_pkg::ST_DATA;
          unique case (kind_q)
            hlz_pkg::KIND_PAIR: begin
              res.out_byte = tog_q ? val_b_q : val_a_q;
              tog_d        = ~tog_q;
            end
            hlz_pkg::KIND_INCR: begin
              res.out_byte = val_a_q;
              val_a_d      = val_a_q + 8'd1;
            end
            hlz_pkg::KIND_COPY, hlz_pkg::KIND_EXT: begin
              res.out_byte = hist_v;
              src_d        = src_q + 17'd1;
            end
            hlz_pkg::KIND_MIRROR: begin
              res.out_byte = hlz_pkg::mirror8(hist_v);
              src_d        = src_q + 17'd1;
            end
            hlz_pkg::KIND_BACKWARD: begin
              res.out_byte = hist_v;
              src_d        = src_q - 17'd1;
            end
            default: res.out_byte = val_a_q;
          endcase
          hist_we   = exec && (out_cnt_q < DepthCnt);
          hist_wd   = res.out_byte;
          out_cnt_d = (out_cnt_q == CountMax) ? CountMax : out_cnt_q + 1'b1;
          rem_d     = rem_dec;
          if (rem_dec == 12'd0) begin
            res.block_last = 1'b1;
            phase_d        = PH_HEADER;
          end else if (kind_q == hlz_pkg::KIND_LITERAL) begin
            phase_d = PH_LITERAL;
          end
        end
      end
      hlz_pkg::OP_RESTART: begin
        phase_d   = PH_HEADER;
        end_d     = END_RUNNING;
        kind_d    = hlz_pkg::KIND_LITERAL;
        rem_d     = 12'd0;
        fhdr_d    = 8'd0;
        val_a_d   = 8'd0;
        val_b_d   = 8'd0;
        src_d     = 17'd0;
        tog_d     = 1'b0;
        in_cnt_d  = '0;
        out_cnt_d = '0;
        res.status = hlz_pkg::ST_ACCEPT;
      end
      default: res.status = hlz_pkg::ST_REFUSE;
    endcase

    // Start a new block from a decoded header.
    if (blk_go) begin
      kind_d  = blk_kind;
      rem_d   = (blk_kind == hlz_pkg::KIND_PAIR) ? {blk_len, 1'b0} : {1'b0, blk_len};
      tog_d   = 1'b0;
      phase_d = (blk_kind == hlz_pkg::KIND_LITERAL) ? PH_LITERAL : PH_OPER_A;
    end

    res.total_in  = 24'(in_cnt_d);
    res.total_out = 24'(out_cnt_d);

    rd_pend_d = exec ? 1'b0 : (issue ? 1'b1 : rd_pend_q);
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      oob_q <= (src_q >= DepthPos);
    end
    if (exec) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      end_q     <= END_RUNNING;
      kind_q    <= hlz_pkg::KIND_LITERAL;
      rem_q     <= 12'd0;
      fhdr_q    <= 8'd0;
      val_a_q   <= 8'd0;
      val_b_q   <= 8'd0;
      src_q     <= 17'd0;
      tog_q     <= 1'b0;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      rd_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_pend_q <= rd_pend_d;
      if (exec) begin
        phase_q   <= phase_d;
        end_q     <= end_d;
        kind_q    <= kind_d;
        rem_q     <= rem_d;
        fhdr_q    <= fhdr_d;
        val_a_q   <= val_a_d;
        val_b_q   <= val_b_d;
        src_q     <= src_d;
        tog_q     <= tog_d;
        in_cnt_q  <= in_cnt_d;
        out_cnt_q <= out_cnt_d;
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end
endmodule

// File: rtl/hal_lz_stream_decompressor_core.sv
// Top level of the streaming LZ decompressor: front queue, back end, history RAM.
//
// Usage:
//   in_i carries one command per transfer: feed a compressed byte, pull one
//   output byte, or restart the stream. out_o returns exactly one result per
//   command, in order: a status code, the data byte and block-end flag for
//   data pulls, and the running input and output byte totals.
//   A command is written into the queue and its result into the result
//   register; pulls in history copy blocks also read the history RAM
//   through its registered port before the byte is formed.
//   Throughput is one command per cycle while out_o.ready stays high; each
//   pull from a copy block stalls the back end for that RAM read.
//   A 2-entry queue decouples input from the back end, and a result register
//   holds the answer while out_o.ready is low; the queue keeps taking input
//   until it is full.
//   Reset clears the queue, the parse state and the totals. History RAM
//   contents are not cleared; the user must see that only bytes produced by the stream are read (not enforced here).
`timescale 1ns / 1ps
module hal_lz_stream_decompressor_core #(
  parameter int HISTORY_DEPTH = 65536,
  parameter int COUNT_WIDTH   = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hlz_stream_if.sink   in_i,
  hlz_stream_if.source out_o
);
  logic              q_valid;
  logic              q_pop;
  hlz_pkg::op_item_t q_item;

  hlz_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  hlz_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );
endmodule

// File: sim/hlz_stream_checker.sv
// Scoreboard for the LZ stream decompressor: predicts each result and compares it.
`timescale 1ns / 1ps
module hlz_stream_checker
  import hlz_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_payload_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_payload_i,
  output int        pending_o,
  output int        errors_o
);

  typedef enum logic [2:0] {
    P_HEADER,
    P_HEADER2,
    P_OPER_A,
    P_OPER_B,
    P_LITERAL,
    P_EMIT
  } parse_e;

  localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;
  localparam int          HIST_DEPTH = 65536;

  logic [7:0]  hist [0:HIST_DEPTH-1];
  logic [23:0] n_in;
  logic [23:0] n_out;
  parse_e      parse;
  logic [2:0]  blk_kind;
  logic [10:0] left;
  logic [7:0]  hdr0;
  logic [7:0]  opa;
  logic [7:0]  opb;
  logic [16:0] src;
  logic        toggle;
  logic        ended;
  status_e     end_code;

  out_item_t   expected_q [$];
  int          errors;

  assign pending_o = expected_q.size();
  assign errors_o  = errors;

  function automatic logic [23:0] bump(input logic [23:0] v);
    return (v == TOTAL_MAX) ? v : v + 24'd1;
  endfunction

  function automatic logic [7:0] flip_bits(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[7 - k] = v[k];
    return r;
  endfunction

  function automatic logic [7:0] hist_at(input logic [16:0] pos);
    return pos[16] ? 8'd0 : hist[pos[15:0]];
  endfunction

  function automatic void clear_parse();
    n_in     = '0;
    n_out    = '0;
    parse    = P_HEADER;
    blk_kind = KIND_LITERAL;
    left     = '0;
    hdr0     = '0;
    opa      = '0;
    opb      = '0;
    src      = '0;
    toggle   = 1'b0;
    ended    = 1'b0;
    end_code = ST_ACCEPT;
  endfunction

  function automatic void open_block(input logic [2:0] code, input logic [11:0] len);
    logic [11:0] cnt;
    blk_kind = (code == KIND_EXT) ? KIND_COPY : code;
    cnt      = (blk_kind == KIND_PAIR) ? len << 1 : len;
    left     = cnt[10:0];
    toggle   = 1'b0;
    parse    = (blk_kind == KIND_LITERAL) ? P_LITERAL : P_OPER_A;
  endfunction

  function automatic status_e take_byte(input logic [7:0] b, input logic l);
    if (ended || parse == P_EMIT) return ST_REFUSE;
    n_in = bump(n_in);
    if (parse == P_HEADER && b == END_MARKER) begin
      ended    = 1'b1;
      end_code = ST_FINISH;
      return ST_FINISH;
    end
    if (l) begin
      ended    = 1'b1;
      end_code = ST_TRUNC;
      return ST_TRUNC;
    end
    case (parse)
      P_HEADER: begin
        if (b[7:5] == HDR_EXTENDED) begin
          hdr0  = b;
          parse = P_HEADER2;
        end else begin
          open_block(b[7:5], {7'd0, b[4:0]} + 12'd1);
        end
      end
      P_HEADER2: open_block(hdr0[4:2], {2'd0, hdr0[1:0], b} + 12'd1);
      P_OPER_A: begin
        opa   = b;
        parse = (blk_kind == KIND_RUN || blk_kind == KIND_INCR) ? P_EMIT : P_OPER_B;
      end
      P_OPER_B: begin
        opb = b;
        if (blk_kind != KIND_PAIR) src = {1'b0, opa, b};
        parse = P_EMIT;
      end
      default: begin
        opa   = b;
        parse = P_EMIT;
      end
    endcase
    return ST_ACCEPT;
  endfunction

  function automatic status_e give_byte(output logic [7:0] v, output logic bl);
    v  = '0;
    bl = 1'b0;
    if (ended) return end_code;
    if (parse != P_EMIT) return ST_NEED;
    case (blk_kind)
      KIND_PAIR: begin
        v      = toggle ? opb : opa;
        toggle = ~toggle;
      end
      KIND_INCR: begin
        v   = opa;
        opa = opa + 8'd1;
      end
      KIND_COPY: begin
        v   = hist_at(src);
        src = src + 17'd1;
      end
      KIND_MIRROR: begin
        v   = flip_bits(hist_at(src));
        src = src + 17'd1;
      end
      KIND_BACKWARD: begin
        if (src == '0) begin
          ended    = 1'b1;
          end_code = ST_UNDER;
          return ST_UNDER;
        end
        v   = hist_at(src);
        src = src - 17'd1;
      end
      default: v = opa;
    endcase
    if (n_out < HIST_DEPTH) hist[n_out[15:0]] = v;
    n_out = bump(n_out);
    left  = left - 11'd1;
    if (left == '0) begin
      bl    = 1'b1;
      parse = P_HEADER;
    end else if (blk_kind == KIND_LITERAL) begin
      parse = P_LITERAL;
    end
    return ST_DATA;
  endfunction

  function automatic out_item_t decode_step(input in_item_t it);
    out_item_t r;
    logic [7:0] v;
    logic bl;
    r = '0;
    case (cmd_e'(it.command))
      CMD_FEED: r.status = take_byte(it.in_byte, it.in_last);
      CMD_PULL: begin
        r.status     = give_byte(v, bl);
        r.out_byte   = v;
        r.block_last = bl;
      end
      CMD_RESTART: begin
        clear_parse();
        r.status = ST_ACCEPT;
      end
      default: r.status = ST_REFUSE;
    endcase
    r.total_in  = n_in;
    r.total_out = n_out;
    return r;
  endfunction

  initial begin
    errors = 0;
    clear_parse();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      clear_parse();
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", out_payload_i);
        end else begin
          want = expected_q.pop_front();
          if (want.status !== out_payload_i.status ||
              want.out_byte !== out_payload_i.out_byte ||
              want.block_last !== out_payload_i.block_last ||
              want.total_in !== out_payload_i.total_in ||
              want.total_out !== out_payload_i.total_out) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %p actual %p", want, out_payload_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(decode_step(in_payload_i));
    end
  end

endmodule

// File: sim/hal_lz_stream_decompressor_core_tb.sv
// Testbench top: drives command streams into the decompressor and gives the verdict.
`timescale 1ns / 1ps
module hal_lz_stream_decompressor_core_tb;
  import hlz_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1000;

  logic clk_i;
  logic rst_ni;
  int   pending;
  int   errors;
  int   cycles;
  int   sent;
  int   produced;
  bit   ended;
  bit   quiet_in;
  bit   hold_req;
  bit   long_done;

  hlz_stream_if #(.payload_t(in_item_t))  in_ch ();
  hlz_stream_if #(.payload_t(out_item_t)) out_ch ();

  hal_lz_stream_decompressor_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  hlz_stream_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_ch.valid),
    .in_ready_i    (in_ch.ready),
    .in_payload_i  (in_ch.payload),
    .out_valid_i   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .out_payload_i (out_ch.payload),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("hal_lz_stream_decompressor_core regression: fail");
      $finish;
    end
  end

  // Result side: random stalls, stall-free stretches, one long hold-off.
  initial begin
    int stall;
    bit quiet_out;
    int taken;
    out_ch.ready = 1'b0;
    taken = 0;
    quiet_out = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (80) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if (taken % 40 == 0) quiet_out = ($urandom_range(0, 3) == 0);
      stall = quiet_out ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      taken++;
    end
  end

  task automatic send(cmd_e c, logic [7:0] b, logic l);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= '{command: c, in_byte: b, in_last: l};
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  // Noise that cannot disturb the parse: refused feeds, unused code.
  task automatic noise_emit();
    case ($urandom_range(0, 7))
      0: send(CMD_FEED, 8'($urandom), 1'($urandom));
      1: send(CMD_UNUSED, 8'($urandom), 1'($urandom));
      default: ;
    endcase
  endtask

  task automatic noise_parse();
    case ($urandom_range(0, 7))
      0: send(CMD_PULL, 8'($urandom), 1'($urandom));
      1: send(CMD_UNUSED, 8'($urandom), 1'($urandom));
      default: ;
    endcase
  endtask

  // Feed an operand; rarely flag it last to truncate mid-block.
  task automatic operand(logic [7:0] b);
    logic l;
    noise_parse();
    l = ($urandom_range(0, 40) == 0);
    send(CMD_FEED, b, l);
    if (l) ended = 1'b1;
  endtask

  task automatic pulls(int n);
    for (int i = 0; i < n; i++) begin
      noise_emit();
      send(CMD_PULL, 8'($urandom), 1'($urandom));
    end
  endtask

  // One block: header, operands, every output byte, or up to the underflow when
  // under is set. Copy sources stay inside what this stream has already produced.
  task automatic emit_block(logic [2:0] kind, int len, bit ext, bit alias7, bit under);
    logic [9:0] lm1;
    logic [2:0] code;
    int src;
    int outs;
    lm1  = 10'(len - 1);
    code = (alias7 && kind == KIND_COPY) ? KIND_EXT : kind;
    noise_parse();
    if (ext || len > 32) begin
      send(CMD_FEED, {HDR_EXTENDED, code, lm1[9:8]}, 1'b0);
      operand(lm1[7:0]);
    end else begin
      send(CMD_FEED, {kind, lm1[4:0]}, 1'b0);
    end
    if (ended) return;
    outs = (kind == KIND_PAIR) ? 2 * len : len;
    case (kind)
      KIND_LITERAL: begin
        for (int i = 0; i < len && !ended; i++) begin
          operand(8'($urandom));
          if (!ended) pulls(1);
        end
        if (!ended) produced += len;
        return;
      end
      KIND_RUN, KIND_INCR: operand(8'($urandom));
      KIND_PAIR: begin
        operand(8'($urandom));
        if (!ended) operand(8'($urandom));
      end
      default: begin
        if (kind == KIND_BACKWARD && under) begin
          src  = $urandom_range(0, (len - 1 < produced - 1) ? len - 1 : produced - 1);
          outs = src;
        end else if (kind == KIND_BACKWARD) begin
          src = $urandom_range(len, produced - 1);
        end else begin
          src = $urandom_range(0, produced - len);
        end
        operand(8'(src >> 8));
        if (!ended) operand(8'(src));
        if (!ended && kind == KIND_BACKWARD && under) begin
          pulls(outs + 1);
          ended = 1'b1;
          produced += outs;
          return;
        end
      end
    endcase
    if (ended) return;
    pulls(outs);
    produced += outs;
  endtask

  task automatic start_stream();
    quiet_in = ($urandom_range(0, 3) == 0);
    send(CMD_RESTART, 8'($urandom), 1'($urandom));
    produced = 0;
    ended    = 1'b0;
  endtask

  task automatic close_stream();
    logic [7:0] b;
    if (!ended) begin
      case ($urandom_range(0, 3))
        0, 1: send(CMD_FEED, END_MARKER, 1'($urandom));
        2: begin
          b = 8'($urandom_range(0, 254));
          send(CMD_FEED, b, 1'b1);
        end
        default: ;
      endcase
      ended = 1'b1;
    end
    repeat ($urandom_range(0, 3)) begin
      send(cmd_e'($urandom_range(0, 1)), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic random_block();
    logic [2:0] kind;
    int len;
    bit ext;
    ext  = ($urandom_range(0, 7) == 0);
    kind = (produced < 2) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(0, 6));
    len  = ext ? $urandom_range(1, 40) : $urandom_range(1, 8);
    if (kind >= KIND_COPY) begin
      if (kind == KIND_BACKWARD && $urandom_range(0, 9) == 0) begin
        emit_block(kind, len, ext, 1'b0, 1'b1);
        return;
      end
      if (len > produced - 1) len = produced - 1;
      if (len < 1) len = 1;
    end
    emit_block(kind, len, ext, 1'($urandom), 1'b0);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    rst_ni    = 1'b0;
    cycles    = 0;
    sent      = 0;
    hold_req  = 1'b0;
    long_done = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: at least one block of each kind, length extremes, edge endings.
    send(CMD_PULL, 8'h00, 1'b0);
    send(CMD_UNUSED, 8'hFF, 1'b1);
    start_stream();
    quiet_in = 1'b0;
    emit_block(KIND_LITERAL, 1, 1'b0, 1'b0, 1'b0);
    emit_block(KIND_RUN, 32, 1'b0, 1'b0, 1'b0);
    emit_block(KIND_PAIR, 1, 1'b0, 1'b0, 1'b0);
    emit_block(KIND_INCR, 3, 1'b1, 1'b0, 1'b0);
    emit_block(KIND_COPY, 4, 1'b0, 1'b0, 1'b0);
    emit_block(KIND_COPY, 3, 1'b1, 1'b1, 1'b0);
    emit_block(KIND_MIRROR, 5, 1'b0, 1'b0, 1'b0);
    emit_block(KIND_BACKWARD, 4, 1'b0, 1'b0, 1'b0);
    emit_block(KIND_BACKWARD, 1024, 1'b0, 1'b0, 1'b1);
    close_stream();
    start_stream();
    send(CMD_FEED, END_MARKER, 1'b0);
    close_stream();
    drain();

    // Random streams; one long result hold-off and occasional full drains.
    hold_req = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      start_stream();
      repeat ($urandom_range(1, 8)) begin
        if (!ended) random_block();
      end
      if (!ended && !long_done) begin
        emit_block(KIND_RUN, 600, 1'b1, 1'b0, 1'b0);
        long_done = 1'b1;
      end
      close_stream();
      if ($urandom_range(0, 4) == 0) drain();
    end
    drain();
    repeat (20) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("hal_lz_stream_decompressor_core regression: pass");
    end else begin
      $display("hal_lz_stream_decompressor_core regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/hlz_pkg.sv
rtl/hlz_stream_if.sv
rtl/hlz_ram.sv
rtl/hlz_front.sv
rtl/hlz_back.sv
rtl/hal_lz_stream_decompressor_core.sv
sim/hlz_stream_checker.sv
sim/hal_lz_stream_decompressor_core_tb.sv
